// File: hw/rtl/byte_stuffed_frame_receiver_unit_assert.svh
// Assertion macros for the frame receiver modules; used by bsfr_ctrl.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef BYTE_STUFFED_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define BYTE_STUFFED_FRAME_RECEIVER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BSFR_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("frame receiver assertion failed");
`define BSFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame receiver assertion failed");
`else
`define BSFR_ASSERT(label, expr)
`define BSFR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: hw/rtl/bsfr_pkg.sv
// Shared types and constants of the byte-stuffed frame receiver.
// No dependencies; used by every module of the block except bsfr_ram.
package bsfr_pkg;

  localparam int BUFFER_BYTES_DEF = 64;
  localparam int LIM_W            = 7;
  localparam int FLEN_W           = 17;
  localparam int PLEN_W           = 6;

  localparam logic [7:0]        FLAG_RST    = 8'd126;
  localparam logic [7:0]        ESC_RST     = 8'd125;
  localparam logic [LIM_W-1:0]  LIMIT_RST   = 7'd64;
  localparam logic [7:0]        ESC_XOR     = 8'h20;
  localparam logic [FLEN_W-1:0] CRC_BYTES   = 17'd4;
  localparam logic [FLEN_W-1:0] MIN_FRAME   = 17'd5;
  localparam logic [31:0]       CRC_POLY    = 32'hEDB88320;
  localparam logic [31:0]       CRC_INIT    = 32'hFFFFFFFF;

  localparam logic [1:0] REG_FLAG   = 2'd0;
  localparam logic [1:0] REG_ESCAPE = 2'd1;
  localparam logic [1:0] REG_LIMIT  = 2'd2;

  typedef enum logic [2:0] {
    S_WAIT,
    S_LEN_LO,
    S_LEN_HI,
    S_BODY,
    S_FETCH,
    S_SHOW
  } ctrl_state_t;

  typedef struct packed {
    logic restart;
    logic set_esc;
    logic consume;
    logic load_lo;
    logic load_hi;
    logic store;
    logic crc_byte;
    logic emit_start;
    logic emit_read;
    logic emit_adv;
  } dp_cmd_t;

  typedef struct packed {
    logic is_flag;
    logic is_esc;
    logic len_ok;
    logic in_payload;
    logic crc_last;
    logic crc_match;
    logic emit_last;
  } dp_status_t;

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/bsfr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bsfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/bsfr_dp.sv
// Datapath of the frame receiver: registers, unstuffing, length check, CRC-32
// and the payload store. Depends on bsfr_pkg and bsfr_ram.
module bsfr_dp #(
  parameter int BUFFER_BYTES = bsfr_pkg::BUFFER_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [7:0]                 rx_byte,
  input  bsfr_pkg::dp_cmd_t          cmd,
  output bsfr_pkg::dp_status_t       sts,
  output logic [7:0]                 payload_byte,
  output logic [bsfr_pkg::PLEN_W-1:0] payload_length,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_idx,
  input  logic [31:0]                cfg_wdata,
  output logic [31:0]                cfg_rdata
);

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int CW = $clog2(BUFFER_BYTES + 1);
  localparam int FW = bsfr_pkg::FLEN_W;
  localparam logic [bsfr_pkg::LIM_W-1:0] BUF_LIM = bsfr_pkg::LIM_W'(BUFFER_BYTES);

  logic [7:0]                 flag_r, flag_nxt;
  logic [7:0]                 esc_r, esc_nxt;
  logic [bsfr_pkg::LIM_W-1:0] limit_r, limit_nxt;
  logic                       esc_pend_r, esc_pend_nxt;
  logic [FW-1:0]              frame_len_r, frame_len_nxt;
  logic [CW-1:0]              byte_cnt_r, byte_cnt_nxt;
  logic [31:0]                rx_crc_r, rx_crc_nxt;
  logic [31:0]                crc_r, crc_nxt;
  logic [AW-1:0]              emit_idx_r, emit_idx_nxt;

  logic [7:0]                 dec;
  logic [FW-1:0]              len_full;
  logic [FW-1:0]              plen;
  logic [bsfr_pkg::LIM_W-1:0] lim_eff;

  assign dec      = esc_pend_r ? (rx_byte ^ bsfr_pkg::ESC_XOR) : rx_byte;
  assign len_full = {1'b0, dec, frame_len_r[7:0]} + bsfr_pkg::CRC_BYTES;
  assign plen     = frame_len_r - bsfr_pkg::CRC_BYTES;
  assign lim_eff  = (limit_r < BUF_LIM) ? limit_r : BUF_LIM;

  always_comb begin
    sts.is_flag    = (rx_byte == flag_r);
    sts.is_esc     = !esc_pend_r && (rx_byte == esc_r);
    sts.len_ok     = (len_full <= FW'(lim_eff)) && (len_full >= bsfr_pkg::MIN_FRAME);
    sts.in_payload = FW'(byte_cnt_r) < plen;
    sts.crc_last   = (FW'(byte_cnt_r) + FW'(1)) == frame_len_r;
    sts.crc_match  = (~crc_r) == {dec, rx_crc_r[31:8]};
    sts.emit_last  = (FW'(emit_idx_r) + FW'(1)) == plen;
  end

  always_comb begin
    flag_nxt      = flag_r;
    esc_nxt       = esc_r;
    limit_nxt     = limit_r;
    esc_pend_nxt  = esc_pend_r;
    frame_len_nxt = frame_len_r;
    byte_cnt_nxt  = byte_cnt_r;
    rx_crc_nxt    = rx_crc_r;
    crc_nxt       = crc_r;
    emit_idx_nxt  = emit_idx_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        bsfr_pkg::REG_FLAG:   flag_nxt  = cfg_wdata[7:0];
        bsfr_pkg::REG_ESCAPE: esc_nxt   = cfg_wdata[7:0];
        bsfr_pkg::REG_LIMIT:  limit_nxt = cfg_wdata[bsfr_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
    if (cmd.restart) begin
      esc_pend_nxt  = 1'b0;
      frame_len_nxt = '0;
      byte_cnt_nxt  = '0;
      rx_crc_nxt    = '0;
      crc_nxt       = bsfr_pkg::CRC_INIT;
    end
    if (cmd.set_esc) begin
      esc_pend_nxt = 1'b1;
    end
    if (cmd.consume) begin
      esc_pend_nxt = 1'b0;
    end
    if (cmd.load_lo) begin
      frame_len_nxt = {{(FW-8){1'b0}}, dec};
    end
    if (cmd.load_hi) begin
      frame_len_nxt = len_full;
    end
    if (cmd.store) begin
      crc_nxt      = bsfr_pkg::crc32_byte(crc_r, dec);
      byte_cnt_nxt = byte_cnt_r + CW'(1);
    end
    if (cmd.crc_byte) begin
      rx_crc_nxt   = {dec, rx_crc_r[31:8]};
      byte_cnt_nxt = byte_cnt_r + CW'(1);
    end
    if (cmd.emit_start) begin
      emit_idx_nxt = '0;
    end
    if (cmd.emit_adv) begin
      emit_idx_nxt = emit_idx_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r      <= bsfr_pkg::FLAG_RST;
      esc_r       <= bsfr_pkg::ESC_RST;
      limit_r     <= bsfr_pkg::LIMIT_RST;
      esc_pend_r  <= 1'b0;
      frame_len_r <= '0;
      byte_cnt_r  <= '0;
      rx_crc_r    <= '0;
      crc_r       <= bsfr_pkg::CRC_INIT;
      emit_idx_r  <= '0;
    end else begin
      flag_r      <= flag_nxt;
      esc_r       <= esc_nxt;
      limit_r     <= limit_nxt;
      esc_pend_r  <= esc_pend_nxt;
      frame_len_r <= frame_len_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      rx_crc_r    <= rx_crc_nxt;
      crc_r       <= crc_nxt;
      emit_idx_r  <= emit_idx_nxt;
    end
  end

  always_comb begin
    unique case (cfg_idx)
      bsfr_pkg::REG_FLAG:   cfg_rdata = {24'd0, flag_r};
      bsfr_pkg::REG_ESCAPE: cfg_rdata = {24'd0, esc_r};
      bsfr_pkg::REG_LIMIT:  cfg_rdata = {{(32-bsfr_pkg::LIM_W){1'b0}}, limit_r};
      default:              cfg_rdata = '0;
    endcase
  end

  bsfr_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (cmd.store),
    .waddr(byte_cnt_r[AW-1:0]),
    .wdata(dec),
    .re   (cmd.emit_read),
    .raddr(emit_idx_r),
    .rdata(payload_byte)
  );

  assign payload_length = plen[bsfr_pkg::PLEN_W-1:0];

endmodule

// File: hw/rtl/bsfr_ctrl.sv
// Controller of the frame receiver: framing phase and payload emission sequence.
// Depends on bsfr_pkg and the assertion macro header.
`include "byte_stuffed_frame_receiver_unit_assert.svh"
module bsfr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  bsfr_pkg::dp_status_t sts,
  output bsfr_pkg::dp_cmd_t    cmd
);

  bsfr_pkg::ctrl_state_t state_r, state_nxt;
  logic in_acc;
  logic out_acc;

  assign in_ready  = (state_r != bsfr_pkg::S_FETCH) && (state_r != bsfr_pkg::S_SHOW);
  assign out_valid = (state_r == bsfr_pkg::S_SHOW);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  always_comb begin
    state_nxt = state_r;
    if (in_acc) begin
      if (sts.is_flag) begin
        state_nxt = bsfr_pkg::S_LEN_LO;
      end else if (state_r != bsfr_pkg::S_WAIT && !sts.is_esc) begin
        unique case (state_r)
          bsfr_pkg::S_LEN_LO: state_nxt = bsfr_pkg::S_LEN_HI;
          bsfr_pkg::S_LEN_HI: state_nxt = sts.len_ok ? bsfr_pkg::S_BODY : bsfr_pkg::S_WAIT;
          bsfr_pkg::S_BODY: begin
            if (!sts.in_payload && sts.crc_last) begin
              state_nxt = sts.crc_match ? bsfr_pkg::S_FETCH : bsfr_pkg::S_WAIT;
            end
          end
          default: ;
        endcase
      end
    end else if (state_r == bsfr_pkg::S_FETCH) begin
      state_nxt = bsfr_pkg::S_SHOW;
    end else if (out_acc) begin
      state_nxt = sts.emit_last ? bsfr_pkg::S_WAIT : bsfr_pkg::S_FETCH;
    end
  end

  always_comb begin
    cmd = '0;
    if (in_acc) begin
      if (sts.is_flag) begin
        cmd.restart = 1'b1;
      end else if (state_r != bsfr_pkg::S_WAIT) begin
        if (sts.is_esc) begin
          cmd.set_esc = 1'b1;
        end else begin
          cmd.consume = 1'b1;
          unique case (state_r)
            bsfr_pkg::S_LEN_LO: cmd.load_lo = 1'b1;
            bsfr_pkg::S_LEN_HI: cmd.load_hi = 1'b1;
            bsfr_pkg::S_BODY: begin
              cmd.store      = sts.in_payload;
              cmd.crc_byte   = !sts.in_payload;
              cmd.emit_start = !sts.in_payload && sts.crc_last && sts.crc_match;
            end
            default: ;
          endcase
        end
      end
    end
    if (state_r == bsfr_pkg::S_FETCH) begin
      cmd.emit_read = 1'b1;
    end
    if (out_acc && !sts.emit_last) begin
      cmd.emit_adv = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bsfr_pkg::S_WAIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  `BSFR_ASSERT(a_no_overlap, !(in_ready && out_valid))
  `BSFR_ASSERT_NEXT(a_flag_restart, in_acc && sts.is_flag, state_r == bsfr_pkg::S_LEN_LO)
  `BSFR_ASSERT_NEXT(a_last_returns, out_acc && sts.emit_last, in_ready)
  `BSFR_ASSERT_NEXT(a_fetch_shows, state_r == bsfr_pkg::S_FETCH, out_valid)

endmodule

// File: hw/rtl/byte_stuffed_frame_receiver_unit.sv
// Top level of the byte-stuffed frame receiver with CRC-32 check.
// Depends on bsfr_pkg, bsfr_ctrl, bsfr_dp and bsfr_ram.
//
// Each received byte is handled in the cycle it is accepted: flag and escape
// detection, the length check and the byte-wide CRC-32 update all complete in that cycle.
// When the last CRC byte of a frame checks good, input is held off and the
// buffered payload is delivered byte by byte, each through a registered read of
// the payload store and then a state that presents it, held there while the output
// stalls; a frame of N payload bytes is N + 7 bytes on the input (flag, two
// length bytes, payload and four CRC bytes, one more for each escape byte). The
// payload store needs no clearing after reset, so the block is ready in the
// cycle after reset is released.
module byte_stuffed_frame_receiver_unit #(
  parameter int BUFFER_BYTES = bsfr_pkg::BUFFER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] payload_byte, [13:8] payload_length, [15:14] zero
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  bsfr_pkg::dp_cmd_t    cmd;
  bsfr_pkg::dp_status_t sts;
  logic [7:0]                  payload_byte;
  logic [bsfr_pkg::PLEN_W-1:0] payload_length;
  logic                        cfg_we;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  bsfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bsfr_dp #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .rx_byte       (in_tdata),
    .cmd           (cmd),
    .sts           (sts),
    .payload_byte  (payload_byte),
    .payload_length(payload_length),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_paddr[3:2]),
    .cfg_wdata     (cfg_pwdata),
    .cfg_rdata     (cfg_prdata)
  );

  assign out_tdata = {2'b00, payload_length, payload_byte};
  assign out_tlast = sts.emit_last;

endmodule
